/* design/particle_neighbor_density_defines.svh */
// Assertion macros shared by the particle neighbor density RTL.
// No dependencies; included by modules that carry assertions.
`ifndef PARTICLE_NEIGHBOR_DENSITY_DEFINES_SVH
`define PARTICLE_NEIGHBOR_DENSITY_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PND_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Implication whose consequence is checked in the next cycle.
`define PND_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

/* design/pnd_pkg.sv */
// Package for the particle neighbor density block: beat types and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pnd_pkg;
    typedef struct packed {
        logic        op;
        logic [5:0]  slot;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic        alive;
        logic [15:0] alpha_in;
    } t_in_beat;

    typedef struct packed {
        logic [5:0]  result_slot;
        logic        is_alive;
        logic [15:0] new_life;
        logic [15:0] new_alpha;
    } t_out_beat;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [0:0] REG_COUNT  = 1'd0;
    localparam logic [0:0] REG_RADIUS = 1'd1;

    localparam logic [19:0] SUM_CAP  = 20'd655360;
    localparam logic [15:0] LIFE_MIN = 16'd3276;
    localparam logic [15:0] LIFE_MAX = 16'd32768;

    // Handshake between the sequencer and the iterative divider/root unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } t_unit_cmd;
endpackage
`default_nettype wire

/* design/particle_neighbor_density.sv */
// Top level of the particle neighbor density block: store, sequencer, APB port.
// Depends on pnd_pkg, pnd_unit and particle_neighbor_density_defines.svh.
//
// Usage: a beat is taken when i_start is high and o_busy low. A load beat
// (op 0) writes one particle entry and produces no result. A query beat
// (op 1) walks entries 0..min(particle_count, MAX_PARTICLES)-1. Each entry
// is fetched in ST_FETCH; for every live neighbor the squared distance is
// then built in ST_MULX, ST_MULY and ST_MULZ, the shared iterative unit takes
// a square root and, if the neighbor lies within the radius at a nonzero
// distance, a reciprocal division. A query of a dead entry walks no
// neighbors. The result, one beat, appears on o_result in the first idle
// cycle, marked by o_result_valid, which is high for exactly one cycle; the
// receiver cannot stall it. Reset clears all alive flags and sets
// particle_count to 64 and neighbor_radius to 192. Positions and alphas are
// undefined until loaded. Registers are to be written by the user over APB
// only while the block is idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "particle_neighbor_density_defines.svh"
module particle_neighbor_density
    import pnd_pkg::*;
#(
    parameter int MAX_PARTICLES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_in_beat    i_item,
    output logic             o_busy,
    output logic             o_result_valid,
    output t_out_beat        o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_FETCH = 9'b000000010,
        ST_MULX  = 9'b000000100,
        ST_MULY  = 9'b000001000,
        ST_MULZ  = 9'b000010000,
        ST_ROOT  = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_LIFE  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    // Entry storage: positions and alphas in memories, alive flags in flops.
    logic [47:0] r_pos_mem [MAX_PARTICLES];
    logic [15:0] r_alpha_mem [MAX_PARTICLES];
    logic [MAX_PARTICLES-1:0] r_alive;

    t_state      r_state, n_state;
    logic [6:0]  r_count;
    logic [14:0] r_radius;
    logic [5:0]  r_slot;
    logic        r_slot_ok;
    logic        r_first;
    logic [AW:0] r_j, n_j;
    logic [AW:0] w_lim;
    logic [47:0] r_self, r_nb;
    logic [47:0] w_nb;
    logic [47:0] r_pos_rd;
    logic [15:0] r_alpha_rd;
    logic [33:0] r_acc;
    logic [19:0] r_sum;
    logic [15:0] r_life;
    logic [16:0] w_dx;
    logic [33:0] w_sq;
    logic        r_valid;
    t_out_beat   w_out;
    t_unit_cmd   w_cmd;
    logic        w_done;
    logic [24:0] w_res;
    logic [33:0] w_opa;
    logic [15:0] w_opb;
    logic        w_wr;
    logic        w_accept;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_alpha_addr;
    logic [25:0] w_sum_add;
    logic [39:0] w_life_mul;
    logic [15:0] w_life_raw;
    logic [32:0] w_alpha_mul;

    assign pready   = 1'b1;
    assign w_wr     = psel && penable && pwrite;
    assign o_busy   = (r_state != ST_IDLE);
    assign w_accept = i_start && !o_busy;
    assign w_lim    = (32'(r_count) > MAX_PARTICLES) ? (AW+1)'(MAX_PARTICLES)
                                                     : (AW+1)'(r_count);

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_COUNT:  prdata = {25'd0, r_count};
            REG_RADIUS: prdata = {17'd0, r_radius};
            default:    prdata = '0;
        endcase
    end

    // Read address: queried slot at start, then each neighbor in turn.
    always_comb begin
        w_rd_addr = r_j[AW-1:0];
        if (r_state == ST_IDLE) w_rd_addr = AW'(i_item.slot);
    end

    // The alpha memory keeps reading the queried entry for the whole query.
    assign w_alpha_addr = (r_state == ST_IDLE) ? AW'(i_item.slot) : AW'(r_slot);

    always_ff @(posedge i_clk) begin
        r_pos_rd   <= r_pos_mem[w_rd_addr];
        r_alpha_rd <= r_alpha_mem[w_alpha_addr];
        if (w_accept && i_item.op == OP_LOAD && 32'(i_item.slot) < MAX_PARTICLES) begin
            r_pos_mem[AW'(i_item.slot)]   <= {i_item.pos_x, i_item.pos_y, i_item.pos_z};
            r_alpha_mem[AW'(i_item.slot)] <= i_item.alpha_in;
        end else if (r_state == ST_OUT && w_out.is_alive) begin
            r_alpha_mem[AW'(r_slot)] <= w_out.new_alpha;
        end
    end

    // Neighbor position: straight from the read port in ST_MULX, held after.
    assign w_nb = (r_state == ST_MULX) ? r_pos_rd : r_nb;

    // Difference for the current axis, one multiply per cycle.
    always_comb begin
        case (r_state)
            ST_MULX: w_dx = 17'($signed(r_self[47:32])) - 17'($signed(w_nb[47:32]));
            ST_MULY: w_dx = 17'($signed(r_self[31:16])) - 17'($signed(w_nb[31:16]));
            default: w_dx = 17'($signed(r_self[15:0]))  - 17'($signed(w_nb[15:0]));
        endcase
        if (w_dx[16]) w_dx = -w_dx;
        w_sq = 34'(w_dx) * 34'(w_dx);
    end

    assign w_sum_add   = 26'(r_sum) + 26'(w_res);
    assign w_life_mul  = 40'(r_sum) * 40'd838861;     // sum/20 via reciprocal
    assign w_life_raw  = 16'(w_life_mul >> 24);
    assign w_alpha_mul = 33'(r_alpha_rd) * 33'(r_life);

    always_comb begin
        n_state = r_state; n_j = r_j;
        w_cmd = '0; w_opa = r_acc; w_opb = r_acc[15:0];
        case (r_state)
            ST_IDLE: begin
                n_j = '0;
                if (w_accept && i_item.op == OP_QUERY) n_state = ST_FETCH;
            end
            ST_FETCH: begin
                if (!r_slot_ok || !r_alive[AW'(r_slot)] || r_j >= w_lim) begin
                    n_state = ST_LIFE;
                end else if (r_alive[r_j[AW-1:0]]) begin
                    n_state = ST_MULX;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_MULX: n_state = ST_MULY;
            ST_MULY: n_state = ST_MULZ;
            ST_MULZ: n_state = ST_ROOT;
            ST_ROOT: begin
                if (w_done) begin
                    if (w_res[16:0] == '0 || w_res[16:0] > 17'(r_radius)) begin
                        n_j = r_j + 1'b1; n_state = ST_FETCH;
                    end else begin
                        w_cmd.start = 1'b1; w_cmd.is_div = 1'b1;
                        w_opa = 34'd1 << 24; w_opb = w_res[15:0];
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (w_done) begin
                    n_j = r_j + 1'b1; n_state = ST_FETCH;
                end
            end
            ST_LIFE: n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_MULZ) begin
            w_cmd.start = 1'b1; w_cmd.is_div = 1'b0; w_opa = r_acc + w_sq;
        end
    end

    pnd_unit u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_opa  (w_opa),
        .i_opb  (w_opb),
        .o_done (w_done),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_count <= 7'd64; r_radius <= 15'd192;
            r_alive <= '0; r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_OUT);
            if (w_wr) begin
                case (paddr[2])
                    REG_COUNT:  r_count  <= pwdata[6:0];
                    REG_RADIUS: r_radius <= pwdata[14:0];
                    default: ;
                endcase
            end
            if (w_accept && i_item.op == OP_LOAD && 32'(i_item.slot) < MAX_PARTICLES)
                r_alive[AW'(i_item.slot)] <= i_item.alive;
        end
        r_j <= n_j;
        case (r_state)
            ST_IDLE: begin
                r_slot <= i_item.slot; r_sum <= '0; r_first <= 1'b1;
                r_slot_ok <= (32'(i_item.slot) < MAX_PARTICLES);
            end
            ST_FETCH: begin
                // The first fetch cycle latches the queried entry read at accept.
                if (r_first) r_self <= r_pos_rd;
                r_first <= 1'b0;
            end
            default: ;
        endcase
        if (r_state == ST_FETCH) begin
            r_acc <= '0;
        end else if (r_state == ST_MULX || r_state == ST_MULY) begin
            r_acc <= r_acc + w_sq;
        end
        if (r_state == ST_DIV && w_done)
            r_sum <= (w_sum_add > 26'(SUM_CAP)) ? SUM_CAP : w_sum_add[19:0];
        if (r_state == ST_LIFE) begin
            r_life <= (w_life_raw < LIFE_MIN) ? LIFE_MIN :
                      (w_life_raw > LIFE_MAX) ? LIFE_MAX : w_life_raw;
        end
    end

    always_comb begin
        w_out.result_slot = r_slot;
        w_out.is_alive    = r_slot_ok && r_alive[AW'(r_slot)];
        w_out.new_life    = w_out.is_alive ? r_life : 16'd0;
        w_out.new_alpha   = !r_slot_ok ? 16'd0 :
                            w_out.is_alive ? 16'(w_alpha_mul >> 17) : r_alpha_rd;
    end

    // The neighbor read issued in ST_FETCH returns during ST_MULX.
    always_ff @(posedge i_clk) begin
        r_nb <= w_nb;
        if (r_state == ST_OUT) o_result <= w_out;
    end

    assign o_result_valid = r_valid;

    `PND_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_result_valid, r_state == ST_IDLE)
    `PND_ASSERT_NEXT(a_out_then_valid, i_clk, i_rst_n, r_state == ST_OUT, o_result_valid)
    `PND_ASSERT_IMP(a_one_hot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
endmodule
`default_nettype wire

/* design/pnd_unit.sv */
// Shared iterative unit: 34-bit integer square root or 25/16-bit division,
// one result bit per cycle. Depends on pnd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pnd_unit
    import pnd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_unit_cmd   i_cmd,
    input  wire logic [33:0] i_opa,
    input  wire logic [15:0] i_opb,
    output logic             o_done,
    output logic [24:0]      o_res
);
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_div, n_div;
    logic [33:0] r_val, n_val;
    logic [35:0] r_rem, n_rem;
    logic [24:0] r_q, n_q;
    logic [15:0] r_b, n_b;
    logic [35:0] w_trial;
    logic [35:0] w_shift;
    logic [24:0] w_q;

    // A start in the cycle that finishes a job loads the next job, while the
    // finished result is still presented on o_res.
    always_comb begin
        n_cnt = r_cnt; n_busy = r_busy; n_div = r_div; n_val = r_val;
        n_rem = r_rem; n_b = r_b; o_done = 1'b0;
        w_shift = '0; w_trial = '0; w_q = r_q;
        if (r_busy) begin
            if (r_div) begin
                w_shift = {r_rem[34:0], r_val[24]};
                n_val = {r_val[32:0], 1'b0};
                w_trial = w_shift - {20'd0, r_b};
                if (!w_trial[35]) begin
                    n_rem = w_trial; w_q = {r_q[23:0], 1'b1};
                end else begin
                    n_rem = w_shift; w_q = {r_q[23:0], 1'b0};
                end
            end else begin
                w_shift = {r_rem[33:0], r_val[33:32]};
                n_val = {r_val[31:0], 2'b00};
                w_trial = w_shift - {17'd0, r_q[16:0], 2'b01};
                if (!w_trial[35]) begin
                    n_rem = w_trial; w_q = {r_q[23:0], 1'b1};
                end else begin
                    n_rem = w_shift; w_q = {r_q[23:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0; o_done = 1'b1;
            end
        end
        n_q = w_q;
        if (i_cmd.start) begin
            n_busy = 1'b1; n_div = i_cmd.is_div; n_val = i_opa; n_b = i_opb;
            n_rem = '0; n_q = '0;
            n_cnt = i_cmd.is_div ? 5'd25 : 5'd17;
        end
    end

    assign o_res = w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_cnt <= n_cnt;
        end
        r_div <= n_div; r_val <= n_val; r_rem <= n_rem; r_q <= n_q; r_b <= n_b;
    end
endmodule
`default_nettype wire
